### hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond) \
  `ASSERT_CLK(label, !(cond))

`endif

### hw/rtl/rcpwm_pkg.sv
package rcpwm_pkg;

  // Number of pins that take part in capture; pins above it only store their level.
  localparam int NumPins = 8;
  localparam int PinCount = 8;
  localparam int PinIdxW = 3;

  localparam logic [PinCount-1:0] PinEnable = PinCount'((32'd1 << NumPins) - 32'd1);

  // Logical receiver channel to physical pin.
  localparam logic [PinIdxW-1:0] ChanToPin [PinCount] = '{
    3'd1, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7
  };

  // Item operations.
  localparam logic OpSample = 1'b0;
  localparam logic OpRead   = 1'b1;

  // Configuration register indexes.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgChannelMask = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinOffWidth = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxOffWidth = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMinOnWidth  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxOnWidth  = 3'd4;

  // Register reset values.
  localparam logic [7:0]  RstChannelMask = 8'd255;
  localparam logic [31:0] RstMinOffWidth = 32'd3000;
  localparam logic [31:0] RstMaxOffWidth = 32'd24000;
  localparam logic [15:0] RstMinOnWidth  = 16'd950;
  localparam logic [15:0] RstMaxOnWidth  = 16'd2075;

  typedef struct packed {
    logic        operation;
    logic [7:0]  pin_levels;
    logic [31:0] timestamp_us;
    logic [2:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [15:0] width_us;
    logic [7:0]  updated_mask;
  } out_item_t;

endpackage

### hw/rtl/rcpwm_in_if.sv
interface rcpwm_in_if;
  logic                valid;
  logic                ready;
  rcpwm_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/rcpwm_out_if.sv
interface rcpwm_out_if;
  logic                 valid;
  logic                 ready;
  rcpwm_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/rc_pwm_pulse_width_capture.sv
// Eight-pin RC PWM pulse-width capture. Each input transfer is either a pin sample
// (eight levels plus a free-running microsecond timestamp) or a read of one logical
// receiver channel; every transfer yields exactly one result transfer. Samples detect
// edges against the previously stored levels, gate them with channel_mask, check the
// low time before a rise against the off-width window and the high time before a fall
// against the on-width window, and store an accepted high time as the pin's good
// width, reporting it in updated_mask. Reads map the channel through the fixed
// channel-to-pin table {1,2,3,0,4,5,6,7} and return that pin's good width without
// touching state. Throughput is one transfer per clock unless out_o.ready holds back the
// result register. An item waits in the input register and its result in the result
// register until it transfers. The per-pin state update is a single read-modify-write
// between those two registers, with all eight pins computed side by side, so consecutive
// samples see each other's effects with no stall.
// Configuration takes effect on the next cycle and must only be written while no
// transfer is in flight.
`include "assert_macros.svh"

module rc_pwm_pulse_width_capture (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rcpwm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [rcpwm_pkg::CfgDataW-1:0]       cfg_data_i,
  rcpwm_in_if.sink                             in_i,
  rcpwm_out_if.source                          out_o
);

  localparam int PinCount = rcpwm_pkg::PinCount;

  // Configuration registers.
  logic [7:0]  channel_mask_q;
  logic [31:0] min_off_width_q;
  logic [31:0] max_off_width_q;
  logic [15:0] min_on_width_q;
  logic [15:0] max_on_width_q;

  // Input register and result register.
  logic                 in_valid_q;
  rcpwm_pkg::in_item_t  in_q;
  logic                 out_valid_q;
  rcpwm_pkg::out_item_t res_q;
  rcpwm_pkg::out_item_t res_d;

  // Capture state.
  logic [PinCount-1:0] last_levels_q, last_levels_d;
  logic [31:0]         rise_stamp_q [PinCount];
  logic [31:0]         rise_stamp_d [PinCount];
  logic [31:0]         fall_stamp_q [PinCount];
  logic [31:0]         fall_stamp_d [PinCount];
  logic [PinCount-1:0] armed_q, armed_d;
  logic [15:0]         good_width_q [PinCount];
  logic [15:0]         good_width_d [PinCount];

  logic                       accept;
  logic                       fire;
  logic                       is_sample;
  logic [PinCount-1:0]        changed;
  logic [PinCount-1:0]        updated;
  logic [31:0]                low_time  [PinCount];
  logic [31:0]                high_time [PinCount];
  logic [PinCount-1:0]        off_ok;
  logic [PinCount-1:0]        on_ok;
  logic [rcpwm_pkg::PinIdxW-1:0] read_pin;
  logic [15:0]                read_width;

  // Handshake: the stage fires when the result register is free or being drained.
  assign fire        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || fire;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = res_q;

  assign is_sample = (in_q.operation == rcpwm_pkg::OpSample);

  // Edges on enabled pins only; disabled pins still store their level.
  assign changed = (in_q.pin_levels ^ last_levels_q) & channel_mask_q & rcpwm_pkg::PinEnable;

  always_comb begin
    last_levels_d = last_levels_q;
    armed_d       = armed_q;
    updated       = '0;
    if (fire && is_sample) begin
      last_levels_d = in_q.pin_levels;
    end
    for (int i = 0; i < PinCount; i++) begin
      // Wrapping differences; the timestamp rolls over modulo 2^32.
      low_time[i]  = in_q.timestamp_us - fall_stamp_q[i];
      high_time[i] = in_q.timestamp_us - rise_stamp_q[i];
      off_ok[i] = (low_time[i] >= min_off_width_q) && (low_time[i] <= max_off_width_q);
      on_ok[i]  = (high_time[i] >= {16'd0, min_on_width_q}) &&
                  (high_time[i] <= {16'd0, max_on_width_q});
      rise_stamp_d[i] = rise_stamp_q[i];
      fall_stamp_d[i] = fall_stamp_q[i];
      good_width_d[i] = good_width_q[i];
      if (fire && is_sample && changed[i]) begin
        if (in_q.pin_levels[i]) begin
          // Rising edge: arm only after a plausible frame gap.
          rise_stamp_d[i] = in_q.timestamp_us;
          armed_d[i]      = off_ok[i];
        end else begin
          // Falling edge: keep the pulse and disarm if armed and in range.
          fall_stamp_d[i] = in_q.timestamp_us;
          if (armed_q[i] && on_ok[i]) begin
            good_width_d[i] = high_time[i][15:0];
            armed_d[i]      = 1'b0;
            updated[i]      = 1'b1;
          end
        end
      end
    end
  end

  // Channel read: pins beyond the enabled count read as zero.
  assign read_pin   = rcpwm_pkg::ChanToPin[in_q.channel];
  assign read_width = (int'(read_pin) < rcpwm_pkg::NumPins) ? good_width_q[read_pin] : 16'd0;

  always_comb begin
    res_d = '0;
    unique case (in_q.operation)
      rcpwm_pkg::OpSample: res_d.updated_mask = updated;
      rcpwm_pkg::OpRead:   res_d.width_us     = read_width;
      default:             res_d              = '0;
    endcase
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_mask_q  <= rcpwm_pkg::RstChannelMask;
      min_off_width_q <= rcpwm_pkg::RstMinOffWidth;
      max_off_width_q <= rcpwm_pkg::RstMaxOffWidth;
      min_on_width_q  <= rcpwm_pkg::RstMinOnWidth;
      max_on_width_q  <= rcpwm_pkg::RstMaxOnWidth;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcpwm_pkg::CfgChannelMask: channel_mask_q  <= cfg_data_i[7:0];
        rcpwm_pkg::CfgMinOffWidth: min_off_width_q <= cfg_data_i;
        rcpwm_pkg::CfgMaxOffWidth: max_off_width_q <= cfg_data_i;
        rcpwm_pkg::CfgMinOnWidth:  min_on_width_q  <= cfg_data_i[15:0];
        rcpwm_pkg::CfgMaxOnWidth:  max_on_width_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold until the next transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i.payload;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Capture state; stamps and widths start at zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_levels_q <= '0;
      armed_q       <= '0;
      for (int i = 0; i < PinCount; i++) begin
        rise_stamp_q[i] <= '0;
        fall_stamp_q[i] <= '0;
        good_width_q[i] <= '0;
      end
    end else begin
      last_levels_q <= last_levels_d;
      armed_q       <= armed_d;
      for (int i = 0; i < PinCount; i++) begin
        rise_stamp_q[i] <= rise_stamp_d[i];
        fall_stamp_q[i] <= fall_stamp_d[i];
        good_width_q[i] <= good_width_d[i];
      end
    end
  end

  `ASSERT_CLK(a_read_keeps_widths,
    (fire && !is_sample) |=> ($stable(good_width_q[0]) && $stable(good_width_q[7])))
  `ASSERT_CLK(a_update_disarms, (fire && is_sample) |=> ((armed_q & res_q.updated_mask) == '0))
  `ASSERT_CLK(a_update_in_mask,
    (fire && is_sample) |=> ((res_q.updated_mask & ~$past(channel_mask_q)) == '0))
  `ASSERT_CLK(a_levels_follow, (fire && is_sample) |=> (last_levels_q == $past(in_q.pin_levels)))

endmodule
